// File: hdl/sdot_pkg.sv
// ----------------------------------------------------------------------------
// sdot_pkg
// shared constants, codes and types of the sorted draw-order table
// ----------------------------------------------------------------------------
`default_nettype none
package sdot_pkg;
    localparam int ENTRIES = 32;
    localparam int HW = 5;
    localparam int CW = 6;
    localparam int KW = 11;
    localparam int MAX_RESULTS = 32;
    localparam logic [KW-1:0] KEY_SCALE = 11'd100;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SCAN   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOTFND  = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef struct packed {
        logic [1:0]    status;
        logic [HW-1:0] handle;
        logic          last;
    } result_t;
endpackage
`default_nettype wire

// File: hdl/sorted_draw_order_table.sv
// ----------------------------------------------------------------------------
// sorted_draw_order_table
// handle pool with a free stack and a key-sorted draw list
// ----------------------------------------------------------------------------
// The list, free stack and per-handle key/visible data live in synchronous
// memories with registered reads. After reset the free stack is filled and
// s_tready stays low until that is done. Create searches the list, reading
// each entry and then its key to compare, and then shifts the tail up by
// a shift read and a shift write per entry; remove searches for the handle
// and shifts down the same way; scan reads the list and emits each visible
// handle as a result item. A reject or an unused code ends at decode. One
// item is in work at a time; results go through a two-entry buffer, and a
// stalled master port holds the sequencer where it waits.
`default_nettype none
module sorted_draw_order_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation[1:0], layer[5:2], priority_req[12:6], visible[13], handle[19:14]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], result_handle[6:2]
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    localparam int HW = sdot_pkg::HW;
    localparam int CW = sdot_pkg::CW;
    localparam int KW = sdot_pkg::KW;
    localparam int N  = sdot_pkg::ENTRIES;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_CRD   = 4'd2;  // read list entry for search
    localparam logic [3:0] S_CKEY  = 4'd3;  // read key of that handle
    localparam logic [3:0] S_CCMP  = 4'd4;
    localparam logic [3:0] S_SHRD  = 4'd5;  // shift read
    localparam logic [3:0] S_SHWR  = 4'd6;  // shift write
    localparam logic [3:0] S_RRD   = 4'd7;
    localparam logic [3:0] S_RCMP  = 4'd8;
    localparam logic [3:0] S_SCRD  = 4'd9;
    localparam logic [3:0] S_SCVIS = 4'd10;
    localparam logic [3:0] S_SCCHK = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;
    localparam logic [3:0] S_FREE  = 4'd13;

    // memories
    logic [HW-1:0] list_mem [N];
    logic [HW-1:0] free_mem [N];
    logic [KW-1:0] key_mem  [N];
    logic          vis_mem  [N];
    logic [N-1:0]  listed_reg;

    logic [3:0]    state_reg;
    logic [1:0]    op_reg;
    logic [KW-1:0] key_reg;
    logic          vis_reg;
    logic [CW-1:0] hin_reg;
    logic [HW-1:0] h_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] ocnt_reg;
    logic [CW-1:0] fcnt_reg;
    logic [CW-1:0] nres_reg;
    logic [CW-1:0] init_reg;     // free stack fill pointer after reset
    logic          pend_reg;     // a scan hit waits to be emitted
    logic [HW-1:0] pend_h_reg;

    logic [HW-1:0] list_q;
    logic [HW-1:0] free_q;
    logic [KW-1:0] key_q;
    logic          vis_q;

    logic          list_we;
    logic [HW-1:0] list_wa;
    logic [HW-1:0] list_wd;
    logic [HW-1:0] list_ra;
    logic          free_we;
    logic [HW-1:0] free_wa;
    logic [HW-1:0] free_wd;
    logic [HW-1:0] key_ra;

    logic              r_valid;
    logic              r_ready;
    sdot_pkg::result_t r_data;
    sdot_pkg::result_t o_data;

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_wa] <= list_wd;
        end
        list_q <= list_mem[list_ra];
        if (free_we)
        begin
            free_mem[free_wa] <= free_wd;
        end
        free_q <= free_mem[fcnt_reg[HW-1:0] - 1'b1];
        if (state_reg == S_FREE)
        begin
            key_mem[h_reg] <= key_reg;
            vis_mem[h_reg] <= vis_reg;
        end
        key_q <= key_mem[key_ra];
        vis_q <= vis_mem[key_ra];
    end

    logic init_busy;
    assign init_busy = (init_reg != CW'(N));
    assign s_tready = (state_reg == S_IDLE) && !init_busy;

    logic [KW-1:0] key_new;
    assign key_new = KW'(s_tdata[5:2]) * sdot_pkg::KEY_SCALE + KW'(s_tdata[12:6]);

    // the pending hit is the last one that may go out
    logic last_scan;
    assign last_scan = (i_reg == ocnt_reg) ||
                       (nres_reg == CW'(sdot_pkg::MAX_RESULTS - 1));

    always_comb
    begin
        list_we = 1'b0;
        list_wa = pos_reg[HW-1:0];
        list_wd = h_reg;
        list_ra = i_reg[HW-1:0];
        free_we = 1'b0;
        free_wa = fcnt_reg[HW-1:0];
        free_wd = h_reg;
        key_ra  = list_q;
        r_valid = 1'b0;
        r_data  = '{status: sdot_pkg::ST_OK, handle: h_reg, last: 1'b1};
        if (init_busy)
        begin
            free_we = 1'b1;
            free_wa = init_reg[HW-1:0];
            free_wd = HW'(N - 1) - init_reg[HW-1:0];
        end
        unique case (state_reg)
            S_SHRD:
            begin
                list_ra = (op_reg == sdot_pkg::OP_CREATE) ? i_reg[HW-1:0] - 1'b1
                                                          : i_reg[HW-1:0];
            end
            S_SHWR:
            begin
                list_we = 1'b1;
                list_wa = (op_reg == sdot_pkg::OP_CREATE) ? i_reg[HW-1:0]
                                                          : i_reg[HW-1:0] - 1'b1;
                list_wd = list_q;
            end
            S_FREE:
            begin
                if (op_reg == sdot_pkg::OP_CREATE)
                begin
                    list_we = 1'b1;
                end
                else
                begin
                    free_we = 1'b1;
                end
                r_valid = 1'b1;
            end
            S_EMIT:
            begin
                r_valid = 1'b1;
                r_data.status = pend_reg ? sdot_pkg::ST_OK : sdot_pkg::ST_NONE;
                r_data.handle = pend_reg ? pend_h_reg : '0;
                r_data.last   = 1'b1;
            end
            S_SCCHK:
            begin
                r_valid = pend_reg && vis_q;
                r_data.handle = pend_h_reg;
                r_data.last   = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_DEC)
        begin
            r_data.last = 1'b1;
        end
    end

    // reject items go out straight from decode
    logic       rej;
    logic [1:0] rej_st;
    always_comb
    begin
        rej = 1'b0;
        rej_st = sdot_pkg::ST_FULL;
        if (op_reg == sdot_pkg::OP_CREATE && fcnt_reg == '0)
        begin
            rej = 1'b1;
        end
        if (op_reg == sdot_pkg::OP_REMOVE &&
            (hin_reg >= CW'(N) || !listed_reg[hin_reg[HW-1:0]]))
        begin
            rej = 1'b1;
            rej_st = sdot_pkg::ST_NOTFND;
        end
    end

    sdot_pkg::result_t r_mux;
    logic              v_mux;
    always_comb
    begin
        r_mux = r_data;
        v_mux = r_valid;
        if (state_reg == S_DEC && rej)
        begin
            v_mux = 1'b1;
            r_mux.status = rej_st;
            r_mux.handle = (rej_st == sdot_pkg::ST_FULL) ? '0 : hin_reg[HW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= s_tdata[1:0];
            key_reg <= key_new;
            vis_reg <= s_tdata[13];
            hin_reg <= s_tdata[19:14];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ocnt_reg   <= '0;
            fcnt_reg   <= CW'(N);
            init_reg   <= '0;
            listed_reg <= '0;
            pos_reg    <= '0;
            i_reg      <= '0;
            nres_reg   <= '0;
            pend_reg   <= 1'b0;
            pend_h_reg <= '0;
            h_reg      <= '0;
        end
        else
        begin
            if (init_busy)
            begin
                init_reg <= init_reg + 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    i_reg    <= '0;
                    nres_reg <= '0;
                    pend_reg <= 1'b0;
                    h_reg    <= (op_reg == sdot_pkg::OP_REMOVE) ? hin_reg[HW-1:0]
                                                                 : free_q;
                    if (rej)
                    begin
                        if (r_ready)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (op_reg == sdot_pkg::OP_CREATE)
                    begin
                        state_reg <= S_CRD;
                    end
                    else if (op_reg == sdot_pkg::OP_REMOVE)
                    begin
                        state_reg <= S_RRD;
                    end
                    else if (op_reg == sdot_pkg::OP_SCAN)
                    begin
                        state_reg <= S_SCRD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CRD:
                begin
                    if (i_reg == ocnt_reg)
                    begin
                        pos_reg   <= i_reg;
                        i_reg     <= ocnt_reg;
                        state_reg <= S_SHRD;
                    end
                    else
                    begin
                        state_reg <= S_CKEY;
                    end
                end
                S_CKEY:
                begin
                    state_reg <= S_CCMP;
                end
                S_CCMP:
                begin
                    if (key_q <= key_reg)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_CRD;
                    end
                    else
                    begin
                        pos_reg   <= i_reg;
                        i_reg     <= ocnt_reg;
                        state_reg <= S_SHRD;
                    end
                end
                S_SHRD:
                begin
                    if (op_reg == sdot_pkg::OP_CREATE && i_reg == pos_reg)
                    begin
                        state_reg <= S_FREE;
                    end
                    else if (op_reg == sdot_pkg::OP_REMOVE && i_reg == ocnt_reg)
                    begin
                        state_reg <= S_FREE;
                    end
                    else
                    begin
                        state_reg <= S_SHWR;
                    end
                end
                S_SHWR:
                begin
                    i_reg     <= (op_reg == sdot_pkg::OP_CREATE) ? i_reg - 1'b1
                                                                 : i_reg + 1'b1;
                    state_reg <= S_SHRD;
                end
                S_RRD:
                begin
                    if (i_reg == ocnt_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RCMP;
                    end
                end
                S_RCMP:
                begin
                    if (list_q == h_reg)
                    begin
                        // shift down: read at i, write at i-1
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_SHRD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_RRD;
                    end
                end
                S_FREE:
                begin
                    if (r_ready)
                    begin
                        if (op_reg == sdot_pkg::OP_CREATE)
                        begin
                            ocnt_reg <= ocnt_reg + 1'b1;
                            fcnt_reg <= fcnt_reg - 1'b1;
                            listed_reg[h_reg] <= 1'b1;
                        end
                        else
                        begin
                            ocnt_reg <= ocnt_reg - 1'b1;
                            fcnt_reg <= fcnt_reg + 1'b1;
                            listed_reg[h_reg] <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_SCRD:
                begin
                    // scan walk bound
                    if (last_scan)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SCVIS;
                    end
                end
                S_SCVIS:
                begin
                    state_reg <= S_SCCHK;
                end
                S_SCCHK:
                begin
                    // a waiting hit is emitted once a later hit is known
                    if (!(pend_reg && vis_q) || r_ready)
                    begin
                        if (pend_reg && vis_q)
                        begin
                            nres_reg <= nres_reg + 1'b1;
                        end
                        if (vis_q && i_reg != ocnt_reg)
                        begin
                            pend_reg   <= 1'b1;
                            pend_h_reg <= list_q;
                        end
                        else
                        begin
                            pend_reg <= pend_reg && !vis_q;
                        end
                        i_reg      <= i_reg + 1'b1;
                        state_reg  <= S_SCRD;
                    end
                end
                S_EMIT:
                begin
                    if (r_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    sdot_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_mux),
        .in_ready  (r_ready),
        .in_data   (r_mux),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (o_data)
    );

    assign m_tdata = {1'b0, o_data.handle, o_data.status};
    assign m_tlast = o_data.last;
endmodule
`default_nettype wire

// File: hdl/sdot_out_reg.sv
// ----------------------------------------------------------------------------
// sdot_out_reg
// two-entry result buffer between the sequencer and the master port
// ----------------------------------------------------------------------------
`default_nettype none
module sdot_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sdot_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sdot_pkg::result_t     out_data
);
    sdot_pkg::result_t buf_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire
